// ----- rtl/core/scrq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrq_pkg: shared types and constants of the service channel request scheduler
// Holds the entry layout, the channel word types, the table write bundle and
// the sequencer state type.
// ----------------------------------------------------------------------------
package scrq_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int SIZE_W    = $clog2(MAX_ITEMS + 1);
    localparam int AGE_W     = 8;

    localparam logic [AGE_W-1:0] TIMEOUT_AGE = 8'd10;
    localparam logic [AGE_W-1:0] AGE_MAX     = 8'hFF;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // one table entry
    typedef struct packed {
        logic [11:0]      address;
        logic             write;
        logic [15:0]      value;
        logic             periodic;
        logic             request;
        logic [AGE_W-1:0] age;
        logic             done;
        logic             error;
    } t_entry;

    // table write port bundle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_tbl_wr;

    // input word
    typedef struct packed {
        logic        cmd;
        logic [3:0]  entry_index;
        logic [11:0] entry_address;
        logic        entry_write;
        logic [15:0] entry_value;
        logic        entry_periodic;
        logic        entry_request;
        logic        crc_ok;
        logic [11:0] resp_address;
        logic        resp_write;
        logic        resp_error;
        logic [15:0] resp_value;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [11:0] tx_address;
        logic        tx_write;
        logic [15:0] tx_value;
        logic        tx_new;
        logic        done_valid;
        logic [3:0]  done_index;
        logic [15:0] done_value;
        logic        done_error;
        logic        timeout_flag;
    } t_out_word;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CUR_RD,
        ST_CUR_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RX_RD,
        ST_RX_CHK,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/scrq_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrq_table: request entry memory
// One write and one registered read a cycle; per-entry valid bits make an
// unwritten entry read as all zero after reset.
// ----------------------------------------------------------------------------
module scrq_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scrq_pkg::t_tbl_wr          i_wr,
    input  logic [scrq_pkg::IDX_W-1:0] i_rd_addr,
    output scrq_pkg::t_entry           o_rd_entry
);
    import scrq_pkg::*;

    t_entry               mem [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_valid;
    t_entry               r_rd_data;
    logic                 r_rd_valid;

    // entry storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // never-written entry reads as zero
    assign o_rd_entry = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- rtl/core/scrq_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrq_seq: frame sequencer
// Steps one word through entry write, cursor check, round-robin scan and
// response completion, one table access per step.
// ----------------------------------------------------------------------------
module scrq_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scrq_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    input  scrq_pkg::t_in_word          i_in_word,
    output logic                        o_idle,
    input  logic                        i_res_free,
    output logic                        o_res_load,
    output scrq_pkg::t_out_word         o_res_word,
    output scrq_pkg::t_tbl_wr           o_tbl_wr,
    output logic [scrq_pkg::IDX_W-1:0]  o_tbl_rd_addr,
    input  scrq_pkg::t_entry            i_tbl_rd
);
    import scrq_pkg::*;

    t_state              r_state, n_state;
    t_in_word            r_in;
    logic [SIZE_W-1:0]   r_item_count;
    logic [IDX_W-1:0]    r_cursor, n_cursor;
    logic [IDX_W-1:0]    r_scan_idx, n_scan_idx;
    logic [IDX_W-1:0]    r_scan_cnt, n_scan_cnt;
    logic [11:0]         r_held_addr, n_held_addr;
    logic                r_held_write, n_held_write;
    logic [15:0]         r_held_value, n_held_value;
    logic                r_tx_new, n_tx_new;
    logic                r_done_valid, n_done_valid;
    logic [3:0]          r_done_index, n_done_index;
    logic [15:0]         r_done_value, n_done_value;
    logic                r_done_error, n_done_error;
    logic                r_timeout, n_timeout;

    logic [SIZE_W-1:0]   s_size;
    logic                s_cur_in;
    logic [SIZE_W-1:0]   s_scan_inc;
    logic [IDX_W-1:0]    s_scan_next;
    logic                s_scan_last;
    logic [SIZE_W-1:0]   s_cur_inc;
    logic [IDX_W-1:0]    s_cur_next;
    logic                s_eligible;
    logic                s_match;
    logic [AGE_W-1:0]    s_age_inc;
    logic                s_accept;

    // effective table size and cursor range
    assign s_size   = (r_item_count > SIZE_W'(MAX_ITEMS)) ? SIZE_W'(MAX_ITEMS) : r_item_count;
    assign s_cur_in = {1'b0, r_cursor} < s_size;

    // wrapped index increments
    assign s_scan_inc  = {1'b0, r_scan_idx} + SIZE_W'(1);
    assign s_scan_next = (s_scan_inc >= s_size) ? '0 : s_scan_inc[IDX_W-1:0];
    assign s_scan_last = ({1'b0, r_scan_cnt} + SIZE_W'(1)) >= s_size;
    assign s_cur_inc   = {1'b0, r_cursor} + SIZE_W'(1);
    assign s_cur_next  = (s_cur_inc >= s_size) ? '0 : s_cur_inc[IDX_W-1:0];

    // entry tests
    assign s_eligible = i_tbl_rd.periodic | i_tbl_rd.request;
    assign s_age_inc  = (i_tbl_rd.age != AGE_MAX) ? i_tbl_rd.age + AGE_W'(1) : i_tbl_rd.age;
    assign s_match    = (r_in.resp_address == i_tbl_rd.address)
                      && (r_in.resp_write == i_tbl_rd.write)
                      && !(r_in.resp_write && !r_in.resp_error
                           && (r_in.resp_value != i_tbl_rd.value));

    assign s_accept = i_in_valid && (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.cmd == CMD_WRITE) begin
                        n_state = ST_WRITE;
                    end else if (s_cur_in) begin
                        n_state = ST_CUR_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WRITE:   n_state = ST_DONE;
            ST_CUR_RD:  n_state = ST_CUR_CHK;
            ST_CUR_CHK: begin
                if (i_tbl_rd.age != '0) begin
                    n_state = r_in.crc_ok ? ST_RX_RD : ST_DONE;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (s_eligible || s_scan_last) begin
                    n_state = r_in.crc_ok ? ST_RX_RD : ST_DONE;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_RX_RD:   n_state = ST_RX_CHK;
            ST_RX_CHK:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // table access and result load
    always_comb begin
        o_tbl_wr       = '0;
        o_tbl_wr.addr  = r_cursor;
        o_tbl_wr.entry = i_tbl_rd;
        o_tbl_rd_addr  = r_cursor;
        o_res_load     = 1'b0;
        case (r_state)
            ST_WRITE: begin
                o_tbl_wr.we             = 1'b1;
                o_tbl_wr.addr           = r_in.entry_index[IDX_W-1:0];
                o_tbl_wr.entry          = '0;
                o_tbl_wr.entry.address  = r_in.entry_address;
                o_tbl_wr.entry.write    = r_in.entry_write;
                o_tbl_wr.entry.value    = r_in.entry_value;
                o_tbl_wr.entry.periodic = r_in.entry_periodic;
                o_tbl_wr.entry.request  = r_in.entry_request;
            end
            ST_CUR_CHK: begin
                o_tbl_wr.we        = (i_tbl_rd.age != '0);
                o_tbl_wr.entry.age = s_age_inc;
            end
            ST_SCAN_RD: begin
                o_tbl_rd_addr = r_scan_idx;
            end
            ST_SCAN_CHK: begin
                o_tbl_wr.we            = s_eligible;
                o_tbl_wr.addr          = r_scan_idx;
                o_tbl_wr.entry.age     = AGE_W'(1);
                o_tbl_wr.entry.request = 1'b0;
            end
            ST_RX_CHK: begin
                o_tbl_wr.we          = s_match;
                o_tbl_wr.entry.age   = '0;
                o_tbl_wr.entry.done  = 1'b1;
                o_tbl_wr.entry.value = r_in.resp_value;
                o_tbl_wr.entry.error = r_in.resp_error;
            end
            ST_DONE: begin
                o_res_load = i_res_free;
            end
            default: begin
                o_res_load = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_cursor     = r_cursor;
        n_scan_idx   = r_scan_idx;
        n_scan_cnt   = r_scan_cnt;
        n_held_addr  = r_held_addr;
        n_held_write = r_held_write;
        n_held_value = r_held_value;
        n_tx_new     = r_tx_new;
        n_done_valid = r_done_valid;
        n_done_index = r_done_index;
        n_done_value = r_done_value;
        n_done_error = r_done_error;
        n_timeout    = r_timeout;
        case (r_state)
            ST_IDLE: begin
                n_tx_new     = 1'b0;
                n_done_valid = 1'b0;
                n_done_index = '0;
                n_done_value = '0;
                n_done_error = 1'b0;
                n_timeout    = 1'b0;
            end
            ST_CUR_CHK: begin
                n_scan_idx = r_cursor;
                n_scan_cnt = '0;
                if ((i_tbl_rd.age != '0) && (s_age_inc == TIMEOUT_AGE)) begin
                    n_timeout = 1'b1;
                end
            end
            ST_SCAN_CHK: begin
                if (s_eligible) begin
                    n_cursor     = r_scan_idx;
                    n_held_addr  = i_tbl_rd.address;
                    n_held_write = i_tbl_rd.write;
                    n_held_value = i_tbl_rd.value;
                    n_tx_new     = 1'b1;
                end else begin
                    n_scan_idx = s_scan_next;
                    n_scan_cnt = r_scan_cnt + IDX_W'(1);
                end
            end
            ST_RX_CHK: begin
                if (s_match) begin
                    n_done_valid = 1'b1;
                    n_done_index = 4'(r_cursor);
                    n_done_value = r_in.resp_value;
                    n_done_error = r_in.resp_error;
                    n_cursor     = s_cur_next;
                end
            end
            default: begin
                n_cursor = r_cursor;
            end
        endcase
    end

    // control and held request registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_item_count <= '0;
            r_cursor     <= '0;
            r_scan_idx   <= '0;
            r_scan_cnt   <= '0;
            r_held_addr  <= '0;
            r_held_write <= 1'b0;
            r_held_value <= '0;
            r_tx_new     <= 1'b0;
            r_done_valid <= 1'b0;
            r_timeout    <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_item_count <= i_cfg_data;
            end
            r_cursor     <= n_cursor;
            r_scan_idx   <= n_scan_idx;
            r_scan_cnt   <= n_scan_cnt;
            r_held_addr  <= n_held_addr;
            r_held_write <= n_held_write;
            r_held_value <= n_held_value;
            r_tx_new     <= n_tx_new;
            r_done_valid <= n_done_valid;
            r_timeout    <= n_timeout;
        end
    end

    // captured word and completion payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= i_in_word;
        end
        r_done_index <= n_done_index;
        r_done_value <= n_done_value;
        r_done_error <= n_done_error;
    end

    assign o_idle = (r_state == ST_IDLE);

    // result word
    always_comb begin
        o_res_word              = '0;
        o_res_word.tx_address   = r_held_addr;
        o_res_word.tx_write     = r_held_write;
        o_res_word.tx_value     = r_held_value;
        o_res_word.tx_new       = r_tx_new;
        o_res_word.done_valid   = r_done_valid;
        o_res_word.done_index   = r_done_index;
        o_res_word.done_value   = r_done_value;
        o_res_word.done_error   = r_done_error;
        o_res_word.timeout_flag = r_timeout;
    end

endmodule

// ----- rtl/core/service_channel_request_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_channel_request_scheduler: service channel request table scheduler
// Keeps the request table, picks the next request round robin, ages busy
// entries and completes them from matching responses.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+----------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_word
//   out     | output    | o_out_valid / i_out_stall | o_out_word
//   cfg     | input     | i_cfg_we                  | i_cfg_data
//
// A table write passes WRITE and DONE. A frame may pass the cursor read and check,
// the scan, which visits one entry at a time through the single table read port,
// and the response read and check before DONE.
// One word is worked at a time; o_in_stall is high until its result is held.
// The result register frees the sequencer; a stalled output holds it at DONE.
// Reset is synchronous active low and clears the table valid bits at once.
// ----------------------------------------------------------------------------
module service_channel_request_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [scrq_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  scrq_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output scrq_pkg::t_out_word         o_out_word
);
    import scrq_pkg::*;

    t_tbl_wr          s_tbl_wr;
    logic [IDX_W-1:0] s_tbl_rd_addr;
    t_entry           s_tbl_rd;
    logic             s_idle;
    logic             s_res_free;
    logic             s_res_load;
    t_out_word        s_res_word;
    logic             r_out_valid;
    t_out_word        r_out_word;

    // request table
    scrq_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (s_tbl_wr),
        .i_rd_addr  (s_tbl_rd_addr),
        .o_rd_entry (s_tbl_rd)
    );

    // frame sequencer
    scrq_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .o_idle        (s_idle),
        .i_res_free    (s_res_free),
        .o_res_load    (s_res_load),
        .o_res_word    (s_res_word),
        .o_tbl_wr      (s_tbl_wr),
        .o_tbl_rd_addr (s_tbl_rd_addr),
        .i_tbl_rd      (s_tbl_rd)
    );

    assign s_res_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !s_idle;

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_load) begin
            r_out_word <= s_res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- rtl/core/scrq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrq_checker: port-level checks of the request scheduler
// Watches the channel ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module scrq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input scrq_pkg::t_out_word o_out_word
);
    import scrq_pkg::*;

    // one word at a time: stall rises right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a word is in work");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("output word changed under stall");

    // completion fields are zero without a completion
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.done_valid) |->
        (o_out_word.done_index == '0 && o_out_word.done_value == '0
         && !o_out_word.done_error))
        else $error("completion fields set without completion");

    // a new request and a timeout come from exclusive branches
    a_new_vs_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.tx_new && o_out_word.timeout_flag))
        else $error("new request and timeout in one word");

endmodule

bind service_channel_request_scheduler scrq_checker u_scrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the service channel request scheduler
// Walks a short directed table, then random table writes and frames, mostly
// responses that answer the entry under the cursor. Every accepted result word
// is compared field by field with a behavioral model kept here or a typed row's
// fixed word, under changing idle patterns on both channels and several table sizes.
// ----------------------------------------------------------------------------
module tb;
    import scrq_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RST_CYCLES  = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 50;
    localparam int CFG_SETTLE  = 4;
    localparam int HOLD_LEN    = 300;
    localparam int CHUNKS      = 6;
    localparam int CHUNK_LEN   = 48;
    localparam int AGE_RUN     = 260;

    // one row of the directed table
    typedef struct {
        bit                cfg_row;
        logic [SIZE_W-1:0] cfg_val;
        t_in_word          word;
        int                reps;
        bit                typed;
        t_out_word         want;
    } t_dir_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [SIZE_W-1:0]  i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;

    // scheduler model state
    t_entry             sched_tbl [MAX_ITEMS];
    int                 sched_cur   = 0;
    logic [SIZE_W-1:0]  sched_count = '0;
    logic [11:0]        held_addr   = '0;
    logic               held_wr     = 1'b0;
    logic [15:0]        held_val    = '0;

    t_out_word          sched_out_q [$];
    t_dir_row           dir_rows [$];
    t_out_word          mon_want;

    int                 err_count      = 0;
    int                 send_gap_pct   = 8;
    int                 recv_stall_pct = 79;
    int                 hold_seq       = 0;
    int                 hold_seen      = 0;
    int                 hold_left      = 0;
    int unsigned        cycle_cnt      = 0;

    service_channel_request_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // scheduler model
    // ------------------------------------------------------------------
    function automatic int used_size();
        return (sched_count < MAX_ITEMS) ? int'(sched_count) : MAX_ITEMS;
    endfunction

    // round robin search from the cursor, -1 when nothing is eligible
    function automatic int next_eligible(input int size);
        int idx;
        int n;
        idx = sched_cur;
        for (n = 0; n < size; n++) begin
            if (sched_tbl[idx].periodic || sched_tbl[idx].request)
                return idx;
            idx++;
            if (idx >= size)
                idx = 0;
        end
        return -1;
    endfunction

    function automatic t_out_word sched_predict(input t_in_word w);
        t_out_word r;
        t_entry    e;
        int        size;
        int        idx;
        bit        hit;
        r    = '0;
        size = used_size();
        if (w.cmd == CMD_WRITE) begin
            e          = '0;
            e.address  = w.entry_address;
            e.write    = w.entry_write;
            e.value    = w.entry_value;
            e.periodic = w.entry_periodic;
            e.request  = w.entry_request;
            sched_tbl[w.entry_index] = e;
        end else begin
            // transmit half: age the busy entry or pick the next one
            if (sched_cur < size) begin
                if (sched_tbl[sched_cur].age != '0) begin
                    if (sched_tbl[sched_cur].age != AGE_MAX)
                        sched_tbl[sched_cur].age = sched_tbl[sched_cur].age + 1'b1;
                    if (sched_tbl[sched_cur].age == TIMEOUT_AGE)
                        r.timeout_flag = 1'b1;
                end else begin
                    idx = next_eligible(size);
                    if (idx >= 0) begin
                        sched_cur              = idx;
                        held_addr              = sched_tbl[idx].address;
                        held_wr                = sched_tbl[idx].write;
                        held_val               = sched_tbl[idx].value;
                        sched_tbl[idx].age     = 8'd1;
                        sched_tbl[idx].request = 1'b0;
                        r.tx_new               = 1'b1;
                    end
                end
            end
            // receive half: a matching response completes the cursor entry
            if (w.crc_ok && sched_cur < size) begin
                e   = sched_tbl[sched_cur];
                hit = (w.resp_address == e.address) && (w.resp_write == e.write);
                if (hit && w.resp_write && !w.resp_error && w.resp_value != e.value)
                    hit = 1'b0;
                if (hit) begin
                    sched_tbl[sched_cur].age   = '0;
                    sched_tbl[sched_cur].done  = 1'b1;
                    sched_tbl[sched_cur].value = w.resp_value;
                    sched_tbl[sched_cur].error = w.resp_error;
                    r.done_valid = 1'b1;
                    r.done_index = 4'(sched_cur);
                    r.done_value = w.resp_value;
                    r.done_error = w.resp_error;
                    sched_cur    = (sched_cur + 1 >= size) ? 0 : sched_cur + 1;
                end
            end
        end
        r.tx_address = held_addr;
        r.tx_write   = held_wr;
        r.tx_value   = held_val;
        return r;
    endfunction

    // entry the next frame will treat as the cursor entry, -1 if none
    function automatic int frame_target();
        int size;
        int idx;
        size = used_size();
        if (sched_cur >= size)
            return -1;
        if (sched_tbl[sched_cur].age != '0)
            return sched_cur;
        idx = next_eligible(size);
        return (idx >= 0) ? idx : sched_cur;
    endfunction

    // ------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------
    function automatic t_in_word entry_word(input int idx, input logic [11:0] addr,
                                            input bit wr, input logic [15:0] val,
                                            input bit per, input bit req);
        t_in_word w;
        w                = '0;
        w.cmd            = CMD_WRITE;
        w.entry_index    = 4'(idx);
        w.entry_address  = addr;
        w.entry_write    = wr;
        w.entry_value    = val;
        w.entry_periodic = per;
        w.entry_request  = req;
        return w;
    endfunction

    function automatic t_in_word frame_word(input bit crc, input logic [11:0] addr,
                                            input bit wr, input bit err,
                                            input logic [15:0] val);
        t_in_word w;
        w              = '0;
        w.cmd          = CMD_FRAME;
        w.crc_ok       = crc;
        w.resp_address = addr;
        w.resp_write   = wr;
        w.resp_error   = err;
        w.resp_value   = val;
        return w;
    endfunction

    function automatic t_in_word rand_in_word();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(t_in_word)-1:0];
    endfunction

    // random word, mostly frames answering the entry in flight
    function automatic t_in_word gen_word();
        t_in_word w;
        t_entry   e;
        int       size;
        int       roll;
        int       tgt;
        w    = rand_in_word();
        size = used_size();
        roll = $urandom_range(99);
        if (roll < 15) begin
            w.cmd            = CMD_WRITE;
            w.entry_periodic = ($urandom_range(2) == 0);
            if (size > 0 && $urandom_range(3) != 0)
                w.entry_index = 4'($urandom_range(size - 1));
        end else begin
            w.cmd    = CMD_FRAME;
            w.crc_ok = ($urandom_range(9) != 0);
            tgt      = frame_target();
            if (tgt >= 0) begin
                e = sched_tbl[tgt];
                if (roll < 80) begin
                    w.resp_address = e.address;
                    w.resp_write   = e.write;
                    w.resp_error   = ($urandom_range(9) == 0);
                    if (e.write && roll < 75)
                        w.resp_value = e.value;
                end else if (roll < 90) begin
                    // near miss on one field
                    w.resp_address = e.address;
                    w.resp_write   = e.write;
                    w.resp_value   = e.value;
                    w.resp_error   = 1'b0;
                    case ($urandom_range(2))
                        0: w.resp_address = e.address ^ (12'd1 << $urandom_range(11));
                        1: w.resp_write = ~e.write;
                        default: w.resp_value = e.value ^ (16'd1 << $urandom_range(15));
                    endcase
                end
            end
        end
        return w;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_count();
        case ($urandom_range(19))
            0: return '0;
            1: return SIZE_W'($urandom_range(31, MAX_ITEMS + 1));
            2: return SIZE_W'(MAX_ITEMS);
            3: return SIZE_W'(1);
            default: return SIZE_W'($urandom_range(MAX_ITEMS, 2));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    task automatic add_word(input t_in_word w, input int reps, input bit typed,
                            input t_out_word want);
        t_dir_row row;
        row         = '{default: '0};
        row.word    = w;
        row.reps    = reps;
        row.typed   = typed;
        row.want    = want;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [SIZE_W-1:0] v);
        t_dir_row row;
        row         = '{default: '0};
        row.cfg_row = 1'b1;
        row.cfg_val = v;
        dir_rows.push_back(row);
    endtask

    task automatic build_dir_rows();
        t_in_word w;
        // empty table size: frame does nothing
        add_word('1, 1, 1'b1, '0);
        // extremes of a table write, held request still clear
        w     = '1;
        w.cmd = CMD_WRITE;
        add_word(w, 1, 1'b1, '0);
        add_word('0, 1, 1'b1, '0);
        add_cfg(SIZE_W'(2));
        add_word(entry_word(0, 12'h001, 1'b0, 16'h5555, 1'b1, 1'b0), 1, 1'b0, '0);
        add_word(entry_word(1, 12'hABC, 1'b1, 16'h1234, 1'b0, 1'b1), 1, 1'b0, '0);
        // bad crc: entry 0 goes out, no completion
        add_word(frame_word(1'b0, 12'h001, 1'b0, 1'b0, 16'hBEEF), 1, 1'b0, '0);
        // read answered
        add_word(frame_word(1'b1, 12'h001, 1'b0, 1'b0, 16'hBEEF), 1, 1'b0, '0);
        // write answered with a different value does not match
        add_word(frame_word(1'b1, 12'hABC, 1'b1, 1'b0, 16'h0000), 1, 1'b0, '0);
        // age up to the timeout
        add_word(frame_word(1'b0, 12'hABC, 1'b1, 1'b0, 16'h1234), 9, 1'b0, '0);
        // error response matches regardless of value
        add_word(frame_word(1'b1, 12'hABC, 1'b1, 1'b1, 16'h00FF), 1, 1'b0, '0);
        // nothing eligible, completion of an idle entry
        add_word(entry_word(0, 12'h001, 1'b0, 16'h0000, 1'b0, 1'b0), 1, 1'b0, '0);
        add_word(frame_word(1'b1, 12'h001, 1'b0, 1'b0, 16'hFFFF), 1, 1'b0, '0);
        // shrink below the cursor
        add_cfg(SIZE_W'(1));
        add_word(frame_word(1'b1, 12'hABC, 1'b1, 1'b1, 16'h00FF), 1, 1'b0, '0);
        // oversized count clamps, scan runs on to the last entry
        add_cfg('1);
        add_word(frame_word(1'b1, 12'hFFF, 1'b1, 1'b0, 16'hFFFF), 1, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word got;
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        got = sched_predict(w);
        sched_out_q.push_back(typed ? want : got);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (sched_out_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_count(input logic [SIZE_W-1:0] v);
        wait_results();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sched_count  = v;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct);
        int ck;
        send_gap_pct   = send_pct;
        recv_stall_pct = recv_pct;
        for (ck = 0; ck < CHUNKS; ck++) begin
            set_count(pick_count());
            // long output hold-off once per phase
            if (ck == 1)
                hold_seq <= hold_seq + 1;
            repeat (CHUNK_LEN) send_word(gen_word(), 1'b0, '0);
        end
    endtask

    // busy entry never answered, age runs into saturation
    task automatic run_age_out();
        t_in_word w;
        int       k;
        set_count(SIZE_W'(MAX_ITEMS));
        w                = rand_in_word();
        w.cmd            = CMD_WRITE;
        w.entry_index    = 4'(sched_cur);
        w.entry_periodic = 1'b1;
        send_word(w, 1'b0, '0);
        for (k = 0; k < AGE_RUN; k++) begin
            w        = rand_in_word();
            w.cmd    = CMD_FRAME;
            w.crc_ok = 1'b0;
            send_word(w, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        foreach (sched_tbl[i])
            sched_tbl[i] = '0;
        build_dir_rows();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_row) begin
                set_count(dir_rows[i].cfg_val);
            end else begin
                repeat (dir_rows[i].reps)
                    send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        run_phase(8, 79);
        run_phase(79, 8);
        run_phase(0, 0);
        run_age_out();

        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && sched_out_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    // receiver stall, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sched_out_q.size() == 0) begin
                $display("%0t: result word with none expected, actual %h", $time, o_out_word);
                err_count++;
            end else begin
                mon_want = sched_out_q.pop_front();
                check_field("tx_address", mon_want.tx_address, o_out_word.tx_address);
                check_field("tx_write", mon_want.tx_write, o_out_word.tx_write);
                check_field("tx_value", mon_want.tx_value, o_out_word.tx_value);
                check_field("tx_new", mon_want.tx_new, o_out_word.tx_new);
                check_field("done_valid", mon_want.done_valid, o_out_word.done_valid);
                check_field("done_index", mon_want.done_index, o_out_word.done_index);
                check_field("done_value", mon_want.done_value, o_out_word.done_value);
                check_field("done_error", mon_want.done_error, o_out_word.done_error);
                check_field("timeout_flag", mon_want.timeout_flag, o_out_word.timeout_flag);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
rtl/core/scrq_pkg.sv
rtl/core/scrq_table.sv
rtl/core/scrq_seq.sv
rtl/core/service_channel_request_scheduler.sv
rtl/core/scrq_checker.sv
test/tb.sv
